// File: hw/rtl/multi_voice_chorus_assert.svh
// assertion helpers for the chorus block, clocked on clock, held off by reset
`ifndef MULTI_VOICE_CHORUS_ASSERT_SVH
`define MULTI_VOICE_CHORUS_ASSERT_SVH

// same-cycle implication
`define MVC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MVC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mvc_pkg.sv
// ----------------------------------------------------------------------------
// mvc_pkg
// shared constants, tables and types of the multi-voice chorus
// ----------------------------------------------------------------------------
package mvc_pkg;

   localparam int DELAY_LENGTH    = 4096;
   localparam int VOICES_MAX      = 3;
   localparam int SAMPLE_BITS     = 16;
   localparam int SINE_TABLE_BITS = 10;

   localparam int AW        = $clog2(DELAY_LENGTH);
   localparam int RINGS     = 2 * VOICES_MAX;
   localparam int RING_W    = $clog2(RINGS);
   localparam int VW        = $clog2(VOICES_MAX + 1);
   localparam int RAM_DEPTH = RINGS * DELAY_LENGTH;
   localparam int RAM_AW    = RING_W + AW;
   localparam int POS_W     = AW + 8;
   localparam int DMAX      = (DELAY_LENGTH - 1) * 256;
   localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
   localparam int QPOS_W    = SINE_TABLE_BITS - 1;
   localparam int WET_W     = SAMPLE_BITS + 9 + VW;
   localparam int REC_K     = WET_W + 3;
   localparam int REC_W     = REC_K + 1;
   localparam int TOT_W     = WET_W + 19;
   localparam int SMAX      = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int SMIN      = -(1 << (SAMPLE_BITS - 1));

   localparam int PHASE_STEP_W  = 24;
   localparam int BASE_DELAY_W  = 20;
   localparam int MOD_DEPTH_W   = 20;
   localparam int MIX_LEVEL_W   = 17;
   localparam int VOICE_COUNT_W = 2;
   localparam int CSR_AW        = 5;
   localparam int CSR_DW        = 32;

   localparam logic [31:0] HALF_RAD_UNITS = 32'd341782638;
   localparam int          Q16_ONE        = 65536;

   localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
   localparam logic [2:0] REG_BASE_DELAY  = 3'd1;
   localparam logic [2:0] REG_MOD_DEPTH   = 3'd2;
   localparam logic [2:0] REG_MIX_LEVEL   = 3'd3;
   localparam logic [2:0] REG_VOICE_COUNT = 3'd4;

   localparam logic [PHASE_STEP_W-1:0]  RST_PHASE_STEP  = 24'd77913;
   localparam logic [BASE_DELAY_W-1:0]  RST_BASE_DELAY  = 20'd225792;
   localparam logic [MOD_DEPTH_W-1:0]   RST_MOD_DEPTH   = 20'd56448;
   localparam logic [MIX_LEVEL_W-1:0]   RST_MIX_LEVEL   = 17'd32768;
   localparam logic [VOICE_COUNT_W-1:0] RST_VOICE_COUNT = 2'd2;

   typedef logic [16:0]      qsine_type [QUARTER+1];
   typedef logic [31:0]      phase_tab_type [VOICES_MAX];
   typedef logic [REC_W-1:0] recip_type [VOICES_MAX+1];

   // quarter-wave sine in q16, odd polynomial with truncating q16 products
   function automatic qsine_type make_qsine();
      qsine_type tab;
      longint t;
      longint t2;
      longint p;
      for (int i = 0; i <= QUARTER; i++) begin
         t  = longint'(i) << (16 - (SINE_TABLE_BITS - 2));
         t2 = (t * t) / 65536;
         p  = -306;
         p  = 5223 + (p * t2) / 65536;
         p  = -42334 + (p * t2) / 65536;
         p  = 102944 + (p * t2) / 65536;
         p  = (p * t) / 65536;
         if (p < 0) p = 0;
         if (p > 65536) p = 65536;
         tab[i] = 17'(p);
      end
      return tab;
   endfunction

   function automatic phase_tab_type make_phase_init();
      phase_tab_type tab;
      for (int v = 0; v < VOICES_MAX; v++) begin
         tab[v] = 32'((64'(v) << 32) / VOICES_MAX);
      end
      return tab;
   endfunction

   function automatic phase_tab_type make_voice_ofs();
      phase_tab_type tab;
      for (int v = 0; v < VOICES_MAX; v++) begin
         tab[v] = 32'(64'(v) * 64'(HALF_RAD_UNITS));
      end
      return tab;
   endfunction

   // ceil(2^REC_K / n), exact quotient for every wet magnitude
   function automatic recip_type make_recip();
      recip_type tab;
      tab[0] = '0;
      for (int n = 1; n <= VOICES_MAX; n++) begin
         tab[n] = REC_W'(((64'(1) << REC_K) + 64'(n - 1)) / 64'(n));
      end
      return tab;
   endfunction

   localparam qsine_type     QSINE      = make_qsine();
   localparam phase_tab_type PHASE_INIT = make_phase_init();
   localparam phase_tab_type VOICE_OFS  = make_voice_ofs();
   localparam recip_type     RECIP      = make_recip();

   typedef struct packed {
      logic [PHASE_STEP_W-1:0]  phase_step;
      logic [BASE_DELAY_W-1:0]  base_delay;
      logic [MOD_DEPTH_W-1:0]   mod_depth;
      logic [MIX_LEVEL_W-1:0]   mix_level;
      logic [VOICE_COUNT_W-1:0] voice_count;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHASE,
      ST_SINE,
      ST_MUL_DELAY,
      ST_DELAY,
      ST_READ_A,
      ST_READ_B,
      ST_MUL_INTERP,
      ST_ACCUM,
      ST_DIVIDE,
      ST_MIX_A,
      ST_MIX_B,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic step_phase;
      logic sine;
      logic mul_delay;
      logic delay;
      logic read_a;
      logic read_b;
      logic mul_interp;
      logic accum;
      logic divide;
      logic mix_a;
      logic mix_b;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_voice;
   } status_type;

endpackage

// File: hw/rtl/mvc_req_if.sv
// ----------------------------------------------------------------------------
// mvc_req_if
// request channel of the chorus: one sample and its channel
// ----------------------------------------------------------------------------
interface mvc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mvc_pkg::SAMPLE_BITS-1:0] sample_in;
   logic                                  channel;

   modport source (output valid, output sample_in, output channel, input ready);
   modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

// File: hw/rtl/mvc_rsp_if.sv
// ----------------------------------------------------------------------------
// mvc_rsp_if
// result channel of the chorus: one chorused sample
// ----------------------------------------------------------------------------
interface mvc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mvc_pkg::SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// File: hw/rtl/mvc_ram.sv
// ----------------------------------------------------------------------------
// mvc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mvc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/mvc_csr.sv
// ----------------------------------------------------------------------------
// mvc_csr
// apb-style register file holding the chorus settings
// ----------------------------------------------------------------------------
module mvc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mvc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [mvc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [mvc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output mvc_pkg::cfg_type            cfg
);

   mvc_pkg::cfg_type cfg_ff;
   mvc_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic             wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            mvc_pkg::REG_PHASE_STEP:
               cfg_in.phase_step = csr_pwdata[mvc_pkg::PHASE_STEP_W-1:0];
            mvc_pkg::REG_BASE_DELAY:
               cfg_in.base_delay = csr_pwdata[mvc_pkg::BASE_DELAY_W-1:0];
            mvc_pkg::REG_MOD_DEPTH:
               cfg_in.mod_depth = csr_pwdata[mvc_pkg::MOD_DEPTH_W-1:0];
            mvc_pkg::REG_MIX_LEVEL:
               cfg_in.mix_level = csr_pwdata[mvc_pkg::MIX_LEVEL_W-1:0];
            mvc_pkg::REG_VOICE_COUNT:
               cfg_in.voice_count = csr_pwdata[mvc_pkg::VOICE_COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step  <= mvc_pkg::RST_PHASE_STEP;
         cfg_ff.base_delay  <= mvc_pkg::RST_BASE_DELAY;
         cfg_ff.mod_depth   <= mvc_pkg::RST_MOD_DEPTH;
         cfg_ff.mix_level   <= mvc_pkg::RST_MIX_LEVEL;
         cfg_ff.voice_count <= mvc_pkg::RST_VOICE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         mvc_pkg::REG_PHASE_STEP:  csr_prdata = 32'(cfg_ff.phase_step);
         mvc_pkg::REG_BASE_DELAY:  csr_prdata = 32'(cfg_ff.base_delay);
         mvc_pkg::REG_MOD_DEPTH:   csr_prdata = 32'(cfg_ff.mod_depth);
         mvc_pkg::REG_MIX_LEVEL:   csr_prdata = 32'(cfg_ff.mix_level);
         mvc_pkg::REG_VOICE_COUNT: csr_prdata = 32'(cfg_ff.voice_count);
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/mvc_ctrl.sv
// ----------------------------------------------------------------------------
// mvc_ctrl
// sequencer of the chorus: walks each voice, then divide, mix and output
// ----------------------------------------------------------------------------
module mvc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mvc_pkg::status_type  status,
   output mvc_pkg::cmd_type     cmd
);

   `include "multi_voice_chorus_assert.svh"

   mvc_pkg::state_type state_ff;
   mvc_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mvc_pkg::ST_IDLE:       if (req_valid) state_in = mvc_pkg::ST_PHASE;
         mvc_pkg::ST_PHASE:      state_in = mvc_pkg::ST_SINE;
         mvc_pkg::ST_SINE:       state_in = mvc_pkg::ST_MUL_DELAY;
         mvc_pkg::ST_MUL_DELAY:  state_in = mvc_pkg::ST_DELAY;
         mvc_pkg::ST_DELAY:      state_in = mvc_pkg::ST_READ_A;
         mvc_pkg::ST_READ_A:     state_in = mvc_pkg::ST_READ_B;
         mvc_pkg::ST_READ_B:     state_in = mvc_pkg::ST_MUL_INTERP;
         mvc_pkg::ST_MUL_INTERP: state_in = mvc_pkg::ST_ACCUM;
         mvc_pkg::ST_ACCUM: begin
            state_in = status.last_voice ? mvc_pkg::ST_DIVIDE : mvc_pkg::ST_PHASE;
         end
         mvc_pkg::ST_DIVIDE:     state_in = mvc_pkg::ST_MIX_A;
         mvc_pkg::ST_MIX_A:      state_in = mvc_pkg::ST_MIX_B;
         mvc_pkg::ST_MIX_B:      state_in = mvc_pkg::ST_DONE;
         mvc_pkg::ST_DONE:       if (out_free) state_in = mvc_pkg::ST_IDLE;
         default:                state_in = mvc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         mvc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         mvc_pkg::ST_PHASE:      cmd.step_phase = 1'b1;
         mvc_pkg::ST_SINE:       cmd.sine       = 1'b1;
         mvc_pkg::ST_MUL_DELAY:  cmd.mul_delay  = 1'b1;
         mvc_pkg::ST_DELAY:      cmd.delay      = 1'b1;
         mvc_pkg::ST_READ_A:     cmd.read_a     = 1'b1;
         mvc_pkg::ST_READ_B:     cmd.read_b     = 1'b1;
         mvc_pkg::ST_MUL_INTERP: cmd.mul_interp = 1'b1;
         mvc_pkg::ST_ACCUM:      cmd.accum      = 1'b1;
         mvc_pkg::ST_DIVIDE:     cmd.divide     = 1'b1;
         mvc_pkg::ST_MIX_A:      cmd.mix_a      = 1'b1;
         mvc_pkg::ST_MIX_B:      cmd.mix_b      = 1'b1;
         mvc_pkg::ST_DONE:       cmd.out_load   = out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MVC_ASSERT_IMP(a_no_overwrite, cmd.out_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `MVC_ASSERT_NXT(a_start_runs, req_valid && req_ready, state_ff == mvc_pkg::ST_PHASE, "no start")
   `MVC_ASSERT_NXT(a_next_voice, (state_ff == mvc_pkg::ST_ACCUM) && !status.last_voice,
                   state_ff == mvc_pkg::ST_PHASE, "voice skipped")

endmodule

// File: hw/rtl/mvc_datapath.sv
// ----------------------------------------------------------------------------
// mvc_datapath
// voice arithmetic, delay rings, lfo phases, voice average and dry/wet mix
// ----------------------------------------------------------------------------
module mvc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mvc_pkg::cmd_type                       cmd,
   output mvc_pkg::status_type                    status,
   input  mvc_pkg::cfg_type                       cfg,
   input  logic signed [mvc_pkg::SAMPLE_BITS-1:0] sample_in,
   input  logic                                   channel,
   output logic signed [mvc_pkg::SAMPLE_BITS-1:0] sample_out
);

   localparam int SB   = mvc_pkg::SAMPLE_BITS;
   localparam int STB  = mvc_pkg::SINE_TABLE_BITS;
   localparam int AW   = mvc_pkg::AW;
   localparam int VW   = mvc_pkg::VW;
   localparam int PW   = mvc_pkg::POS_W;
   localparam int WW   = mvc_pkg::WET_W;
   localparam int TW   = mvc_pkg::TOT_W;
   localparam int IPW  = SB + 10;

   // item registers
   logic signed [SB-1:0]  dry_ff;
   logic                  chan_ff;
   logic [VW-1:0]         nv_ff;
   logic [VW-1:0]         voice_ff;
   logic [VW-1:0]         nv_in;

   // per-ring state
   logic [31:0]           phase_ff [mvc_pkg::RINGS];
   logic [AW-1:0]         wp_ff    [mvc_pkg::RINGS];
   logic                  wrap_ff  [mvc_pkg::RINGS];

   // voice pipeline registers
   logic [31:0]           phase_new_ff;
   logic [31:0]           angle_ff;
   logic [16:0]           lfo_ff;
   logic [20:0]           mprod_ff;
   logic [PW-1:0]         dly_ff;
   logic [7:0]            frac_ff;
   logic [AW-1:0]         ni_ff;
   logic                  va_ff;
   logic                  vb_ff;
   logic signed [SB-1:0]  a_ff;
   logic signed [IPW-1:0] iprod_ff;
   logic signed [WW-1:0]  wet_ff;
   logic signed [WW-1:0]  wq_ff;
   logic signed [SB+17:0] p1_ff;
   logic signed [WW+17:0] p2_ff;
   logic signed [SB-1:0]  out_ff;

   logic [mvc_pkg::RING_W-1:0] ring;
   logic [31:0]                cur_phase;
   logic [AW-1:0]              cur_wp;
   logic                       cur_wrap;

   // sine lookup
   logic [STB-1:0]             sidx;
   logic [1:0]                 quad;
   logic [mvc_pkg::QPOS_W-1:0] qpos;
   logic [16:0]                qval;
   logic [17:0]                lfo_sum;

   // delay and read address
   logic [36:0]           mprod;
   logic [21:0]           dsum;
   logic [PW-1:0]         pos8;
   logic [AW-1:0]         ri;

   // ram ports
   logic                          ram_we;
   logic [mvc_pkg::RAM_AW-1:0]    ram_waddr;
   logic [mvc_pkg::RAM_AW-1:0]    ram_raddr;
   logic [SB-1:0]                 ram_rdata;

   // interpolation, average and mix
   logic signed [SB-1:0]  b_val;
   logic signed [SB:0]    diff;
   logic signed [WW-1:0]  interp;
   logic [WW-1:0]         mag;
   logic [WW+mvc_pkg::REC_W-1:0] qprod;
   logic [WW-1:0]         quot;
   logic [16:0]           mixc;
   logic [17:0]           inv_mix;
   logic signed [TW-1:0]  total;
   logic signed [TW-1:0]  res;
   logic signed [SB-1:0]  sat;

   assign ring      = mvc_pkg::RING_W'({voice_ff, chan_ff});
   assign cur_phase = phase_ff[ring];
   assign cur_wp    = wp_ff[ring];
   assign cur_wrap  = wrap_ff[ring];

   always_comb begin
      if (cfg.voice_count == '0) begin
         nv_in = VW'(1);
      end else if (int'(cfg.voice_count) > mvc_pkg::VOICES_MAX) begin
         nv_in = VW'(mvc_pkg::VOICES_MAX);
      end else begin
         nv_in = VW'(cfg.voice_count);
      end
   end

   assign status.last_voice = (voice_ff == (nv_ff - VW'(1)));

   // quarter-wave folding of the table index
   assign sidx = angle_ff[31 -: STB];
   assign quad = sidx[STB-1 -: 2];
   assign qpos = quad[0] ? mvc_pkg::QPOS_W'(mvc_pkg::QUARTER - int'(sidx[STB-3:0]))
                         : mvc_pkg::QPOS_W'(sidx[STB-3:0]);
   assign qval = mvc_pkg::QSINE[qpos];
   assign lfo_sum = quad[1] ? (18'(mvc_pkg::Q16_ONE) - 18'(qval))
                            : (18'(mvc_pkg::Q16_ONE) + 18'(qval));

   assign mprod = 37'(lfo_ff) * 37'(cfg.mod_depth);
   assign dsum  = 22'(cfg.base_delay) + 22'(mprod_ff);

   // ring span is a power of two, so the wrap is the natural overflow
   assign pos8 = {cur_wp, 8'd0} - dly_ff;
   assign ri   = pos8[PW-1:8];

   always_comb begin
      ram_raddr = {ring, ri};
      if (cmd.read_b) begin
         ram_raddr = {ring, ni_ff};
      end
   end

   assign ram_we    = cmd.accum;
   assign ram_waddr = {ring, cur_wp};

   assign b_val  = vb_ff ? $signed(ram_rdata) : '0;
   assign diff   = (SB+1)'(b_val) - (SB+1)'(a_ff);
   assign interp = (WW'(a_ff) <<< 8) + WW'(iprod_ff);

   assign mag   = wet_ff[WW-1] ? WW'(-wet_ff) : WW'(wet_ff);
   assign qprod = (WW+mvc_pkg::REC_W)'(mag) * (WW+mvc_pkg::REC_W)'(mvc_pkg::RECIP[nv_ff]);
   assign quot  = qprod[mvc_pkg::REC_K +: WW];

   assign mixc    = (cfg.mix_level > 17'(mvc_pkg::Q16_ONE)) ? 17'(mvc_pkg::Q16_ONE)
                                                            : cfg.mix_level;
   assign inv_mix = 18'(mvc_pkg::Q16_ONE) - 18'(mixc);

   assign total = (TW'(p1_ff) <<< 8) + TW'(p2_ff);
   assign res   = total >>> 24;

   always_comb begin
      if (res > TW'(mvc_pkg::SMAX)) begin
         sat = SB'(mvc_pkg::SMAX);
      end else if (res < TW'(mvc_pkg::SMIN)) begin
         sat = SB'(mvc_pkg::SMIN);
      end else begin
         sat = res[SB-1:0];
      end
   end

   mvc_ram #(
      .WIDTH (SB),
      .DEPTH (mvc_pkg::RAM_DEPTH)
   ) u_ring_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (dry_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // per-ring phase, write pointer and fill flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mvc_pkg::RINGS; r++) begin
            phase_ff[r] <= mvc_pkg::PHASE_INIT[r >> 1];
            wp_ff[r]    <= '0;
            wrap_ff[r]  <= 1'b0;
         end
      end else if (cmd.accum) begin
         phase_ff[ring] <= phase_new_ff;
         wp_ff[ring]    <= cur_wp + AW'(1);
         if (cur_wp == '1) begin
            wrap_ff[ring] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_ff <= '0;
      end else if (cmd.start) begin
         voice_ff <= '0;
      end else if (cmd.accum) begin
         voice_ff <= voice_ff + VW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dry_ff  <= sample_in;
         chan_ff <= channel;
         nv_ff   <= nv_in;
         wet_ff  <= '0;
      end
      if (cmd.step_phase) begin
         phase_new_ff <= cur_phase + 32'(cfg.phase_step);
         angle_ff     <= cur_phase + 32'(cfg.phase_step) + mvc_pkg::VOICE_OFS[voice_ff];
      end
      if (cmd.sine) begin
         lfo_ff <= lfo_sum[17:1];
      end
      if (cmd.mul_delay) begin
         mprod_ff <= mprod[36:16];
      end
      if (cmd.delay) begin
         dly_ff <= (dsum > 22'(mvc_pkg::DMAX)) ? PW'(mvc_pkg::DMAX) : PW'(dsum);
      end
      if (cmd.read_a) begin
         frac_ff <= pos8[7:0];
         ni_ff   <= ri + AW'(1);
         va_ff   <= cur_wrap || (ri < cur_wp);
      end
      if (cmd.read_b) begin
         a_ff  <= va_ff ? $signed(ram_rdata) : '0;
         vb_ff <= cur_wrap || (ni_ff < cur_wp);
      end
      if (cmd.mul_interp) begin
         iprod_ff <= IPW'(diff) * $signed({1'b0, frac_ff});
      end
      if (cmd.accum) begin
         wet_ff <= wet_ff + interp;
      end
      if (cmd.divide) begin
         wq_ff <= wet_ff[WW-1] ? $signed(-quot) : $signed(quot);
      end
      if (cmd.mix_a) begin
         p1_ff <= (SB+18)'(dry_ff) * $signed({1'b0, inv_mix});
      end
      if (cmd.mix_b) begin
         p2_ff <= (WW+18)'(wq_ff) * $signed({1'b0, mixc});
      end
      if (cmd.out_load) begin
         out_ff <= sat;
      end
   end

   assign sample_out = out_ff;

endmodule

// File: hw/rtl/multi_voice_chorus.sv
// ----------------------------------------------------------------------------
// multi_voice_chorus
// stereo chorus of up to three lfo-modulated delay voices per channel
// ----------------------------------------------------------------------------
// usage:
//   req_ch carries one request: a signed sample and its channel (0 left,
//   1 right). rsp_ch returns one chorused sample per request, in order.
//   settings are written over the csr_ apb port while the block is idle.
// timing:
//   a request is taken in the idle state; each active voice then steps
//   through phase, sine, depth multiply, delay, two ring reads,
//   interpolate and accumulate. divide, the mix steps and done follow;
//   the result is registered in done once the output register is free,
//   and only then is the next request taken in the idle state.
// reset:
//   settings return to defaults, phases to their thirds of a turn, write
//   pointers to zero; ring cells never written read as zero by a per-ring
//   fill flag, so no clearing pass is needed.
// stall:
//   a waiting result sits in the output register; the next result is held
//   in the datapath until rsp_ch.ready frees that register.
// ----------------------------------------------------------------------------
module multi_voice_chorus (
   input  logic                        clock,
   input  logic                        reset,
   mvc_req_if.sink                     req_ch,
   mvc_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mvc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [mvc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [mvc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   mvc_pkg::cfg_type    cfg;
   mvc_pkg::cmd_type    cmd;
   mvc_pkg::status_type status;

   mvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mvc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .sample_in  (req_ch.sample_in),
      .channel    (req_ch.channel),
      .sample_out (rsp_ch.sample_out)
   );

endmodule
